/* hw/rtl/sorted_key_set_engine_macros.svh */
// Assertion macros shared by the sorted key set engine RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SORTED_KEY_SET_ENGINE_MACROS_SVH
`define SORTED_KEY_SET_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted key set engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted key set engine: next-cycle check failed");

`endif

/* hw/rtl/sks_pkg.sv */
// Shared types and constants for the sorted key set engine.
// No dependencies; used by sks_cell and sorted_key_set_engine.
package sks_pkg;

    localparam int unsigned KEY_W        = 16;
    localparam int unsigned MODE_W       = 2;
    localparam int unsigned COUNT_OUT_W  = 7;
    localparam int unsigned CAPACITY_DEF = 64;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [KEY_W-1:0]  t_key;

    localparam t_mode MODE_MEMBER = 2'd0;
    localparam t_mode MODE_INSERT = 2'd1;
    localparam t_mode MODE_DELETE = 2'd2;
    localparam t_mode MODE_CLEAR  = 2'd3;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic cmp_en;   // latch compare flags against the broadcast key
        logic ins_en;   // shift up from the lower neighbor, drop key at its slot
        logic del_en;   // shift down from the upper neighbor
    } t_cell_ctl;

endpackage

/* hw/rtl/sks_cell.sv */
// One slot of the sorted key chain: a key register plus compare flags.
// Depends on sks_pkg; instantiated in a row by sorted_key_set_engine.
module sks_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = $clog2(sks_pkg::CAPACITY_DEF + 1)
) (
    input  logic              i_clk,
    input  sks_pkg::t_cell_ctl i_ctl,
    input  sks_pkg::t_key     i_key,
    input  logic [CW-1:0]     i_count,
    input  logic              i_prev_lt,
    input  sks_pkg::t_key     i_prev_key,
    input  sks_pkg::t_key     i_next_key,
    output sks_pkg::t_key     o_key,
    output logic              o_lt,
    output logic              o_eq
);

    sks_pkg::t_key r_key;
    logic          r_lt;
    logic          r_eq;
    logic          occ;

    // slot holds a live key when its index is below the count
    assign occ = (i_count > CW'(IDX));

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_lt <= occ && (r_key < i_key);
            r_eq <= occ && (r_key == i_key);
        end
        // keys below the target stay put; the rest move one slot
        if (i_ctl.ins_en && !r_lt) begin
            r_key <= i_prev_lt ? i_key : i_prev_key;
        end else if (i_ctl.del_en && !r_lt) begin
            r_key <= i_next_key;
        end
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

/* hw/rtl/sorted_key_set_engine.sv */
// Sorted key set engine: CAPACITY unique 16-bit keys kept ascending in a chain of cells.
// Result: o_strobe is registered from the apply state, after the compare state; one result beat per command.
// One command at a time: busy stays high through the compare and the shift/update in all cells.
// Reset (i_rst_n low, synchronous): set empty, FSM idle, no strobe; key slots are not cleared.
// The receiver cannot stall: o_strobe marks each result beat for exactly one cycle.
// Depends on sks_pkg, sks_cell and sorted_key_set_engine_macros.svh.
`include "sorted_key_set_engine_macros.svh"

module sorted_key_set_engine #(
    parameter int unsigned CAPACITY = sks_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sks_pkg::MODE_W-1:0]        i_mode,
    input  logic [sks_pkg::KEY_W-1:0]         i_key,
    output logic                              o_strobe,
    output logic                              o_success,
    output logic                              o_full_res,
    output logic [sks_pkg::COUNT_OUT_W-1:0]   o_entry_count
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CMP   = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    sks_pkg::t_mode     r_mode;
    sks_pkg::t_key      r_key;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_strobe;
    logic               r_success;
    logic               n_success;
    logic               r_full;
    logic               n_full;

    sks_pkg::t_cell_ctl ctl;
    logic               do_ins;
    logic               do_del;
    logic               present;
    logic               is_full;

    // chain wiring, padded at both ends so every cell sees neighbors
    sks_pkg::t_key      key_pad [CAPACITY+2];
    logic [CAPACITY:0]  lt_pad;
    logic [CAPACITY-1:0] eq_vec;

    logic accept;
    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // ------------------------------------------------------------------
    // Cell row. Cell g holds slot g; slot 0 sees a "below" flag of 1 so
    // an insert at the head drops the new key there.
    // ------------------------------------------------------------------
    assign lt_pad[0]              = 1'b1;
    assign key_pad[0]             = r_key;
    assign key_pad[CAPACITY+1]    = key_pad[CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sks_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_key      (r_key),
            .i_count    (r_count),
            .i_prev_lt  (lt_pad[g]),
            .i_prev_key (key_pad[g]),
            .i_next_key (key_pad[g+2]),
            .o_key      (key_pad[g+1]),
            .o_lt       (lt_pad[g+1]),
            .o_eq       (eq_vec[g])
        );
    end

    // keys are unique, so at most one cell reports a match
    assign present = |eq_vec;
    assign is_full = (r_count == CW'(CAPACITY));

    // ------------------------------------------------------------------
    // Decision in the apply cycle, from the flags latched by the cells.
    // ------------------------------------------------------------------
    always_comb begin
        n_count   = r_count;
        n_success = 1'b0;
        n_full    = 1'b0;
        do_ins    = 1'b0;
        do_del    = 1'b0;
        unique case (r_mode)
            sks_pkg::MODE_MEMBER: begin
                n_success = present;
            end
            sks_pkg::MODE_INSERT: begin
                if (!present) begin
                    if (is_full) begin
                        n_full = 1'b1;
                    end else begin
                        do_ins    = 1'b1;
                        n_success = 1'b1;
                        n_count   = r_count + CW'(1);
                    end
                end
            end
            sks_pkg::MODE_DELETE: begin
                if (present) begin
                    do_del    = 1'b1;
                    n_success = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            sks_pkg::MODE_CLEAR: begin
                n_success = 1'b1;
                n_count   = '0;
            end
        endcase
    end

    always_comb begin
        ctl.cmp_en = (r_state == ST_CMP);
        ctl.ins_en = (r_state == ST_APPLY) && do_ins;
        ctl.del_en = (r_state == ST_APPLY) && do_del;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_CMP;
            ST_CMP:   n_state = ST_APPLY;
            ST_APPLY: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // command beat and result capture (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_key  <= i_key;
        end
        if (r_state == ST_APPLY) begin
            r_success <= n_success;
            r_full    <= n_full;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_APPLY);
            if (r_state == ST_APPLY) begin
                r_count <= n_count;
            end
        end
    end

    assign o_strobe      = r_strobe;
    assign o_success     = r_success;
    assign o_full_res    = r_full;
    assign o_entry_count = sks_pkg::COUNT_OUT_W'(r_count);

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SKS_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `SKS_ASSERT_IMPL(a_full_not_ok, i_clk, i_rst_n, r_strobe && r_full, !r_success)
    `SKS_ASSERT_NEXT(a_accept_cmp, i_clk, i_rst_n, accept, r_state == ST_CMP)
    `SKS_ASSERT_NEXT(a_apply_strobe, i_clk, i_rst_n, r_state == ST_APPLY,
                     r_strobe && (r_state == ST_IDLE))

endmodule

/* tb/sorted_key_set_engine_checker.sv */
// Scoreboard for the sorted key set engine: shadows the key set, predicts each result beat.
// Depends on sks_pkg; instantiated next to the engine by sorted_key_set_engine_tb.
module sorted_key_set_engine_checker #(
    parameter int unsigned CAPACITY = sks_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  sks_pkg::t_mode                  i_mode,
    input  sks_pkg::t_key                   i_key,
    input  logic                            i_strobe,
    input  logic                            i_success,
    input  logic                            i_full_res,
    input  logic [sks_pkg::COUNT_OUT_W-1:0] i_entry_count,
    output int                              o_errors,
    output int                              o_pending
);

    typedef struct packed {
        logic                            success;
        logic                            full_res;
        logic [sks_pkg::COUNT_OUT_W-1:0] entry_count;
    } t_set_result;

    // Shadow copy of the set: entries below held_n are valid and ascending.
    sks_pkg::t_key held_keys [CAPACITY];
    int unsigned   held_n;
    t_set_result   due_results [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        held_n    = 0;
    end

    // Applies one command to the shadow set and returns the beat it should produce.
    function automatic t_set_result apply_command(input sks_pkg::t_mode mode,
                                                  input sks_pkg::t_key key);
        int unsigned pos;
        int unsigned i;
        logic        present;
        t_set_result res;
        pos = 0;
        while (pos < held_n && held_keys[pos] < key)
            pos++;
        present = (pos < held_n) && (held_keys[pos] == key);
        res     = '0;
        case (mode)
            sks_pkg::MODE_MEMBER: begin
                res.success = present;
            end
            sks_pkg::MODE_INSERT: begin
                if (!present) begin
                    if (held_n >= CAPACITY) begin
                        res.full_res = 1'b1;
                    end else begin
                        for (i = held_n; i > pos; i--)
                            held_keys[i] = held_keys[i-1];
                        held_keys[pos] = key;
                        held_n++;
                        res.success = 1'b1;
                    end
                end
            end
            sks_pkg::MODE_DELETE: begin
                if (present) begin
                    for (i = pos; i + 1 < held_n; i++)
                        held_keys[i] = held_keys[i+1];
                    held_n--;
                    res.success = 1'b1;
                end
            end
            default: begin
                held_n      = 0;
                res.success = 1'b1;
            end
        endcase
        res.entry_count = sks_pkg::COUNT_OUT_W'(held_n);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        o_errors++;
        $display("%0t checker: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_set_result want;
        if (!i_rst_n) begin
            held_n = 0;
            due_results.delete();
        end else begin
            if (i_strobe) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding");
                end else begin
                    want = due_results.pop_front();
                    if (i_success !== want.success)
                        report_mismatch($sformatf("success %b, want %b",
                                                  i_success, want.success));
                    if (i_full_res !== want.full_res)
                        report_mismatch($sformatf("full_res %b, want %b",
                                                  i_full_res, want.full_res));
                    if (i_entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count %0d, want %0d",
                                                  i_entry_count, want.entry_count));
                end
            end
            if (i_start && i_busy === 1'b0)
                due_results.push_back(apply_command(i_mode, i_key));
        end
        o_pending = due_results.size();
    end

endmodule

/* tb/sorted_key_set_engine_tb.sv */
// Top of the sorted key set engine bench: clock, reset, command stimulus and the verdict.
// Depends on sks_pkg, the engine RTL and sorted_key_set_engine_checker.
module sorted_key_set_engine_tb;

    localparam int unsigned CAP       = sks_pkg::CAPACITY_DEF;
    // Roughly 830 commands, each with its engine pass and an optional idle gap,
    // plus drains; the limit leaves ample margin on top.
    localparam int          MAX_CYCLES = 150000;

    logic                            i_clk   = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start   = 1'b0;
    sks_pkg::t_mode                  i_mode  = sks_pkg::MODE_MEMBER;
    sks_pkg::t_key                   i_key   = '0;
    logic                            busy;
    logic                            o_strobe;
    logic                            o_success;
    logic                            o_full_res;
    logic [sks_pkg::COUNT_OUT_W-1:0] o_entry_count;

    int errors;
    int pending;
    int cycles = 0;
    int idle_pct = 0;   // chance, in percent, of a gap after each accepted beat

    sorted_key_set_engine #(.CAPACITY(CAP)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .o_strobe      (o_strobe),
        .o_success     (o_success),
        .o_full_res    (o_full_res),
        .o_entry_count (o_entry_count)
    );

    sorted_key_set_engine_checker #(.CAPACITY(CAP)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_strobe      (o_strobe),
        .i_success     (o_success),
        .i_full_res    (o_full_res),
        .i_entry_count (o_entry_count),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result beat ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Presents one command and holds it until the engine takes it (start high, busy low).
    // Start stays high into the next command unless a gap is rolled; during a gap the
    // payload ports carry junk, which must be ignored while start is low.
    task automatic issue(input sks_pkg::t_mode mode, input sks_pkg::t_key key);
        start  <= 1'b1;
        i_mode <= mode;
        i_key  <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start  <= 1'b0;
            i_mode <= sks_pkg::t_mode'($urandom);
            i_key  <= sks_pkg::t_key'($urandom);
            repeat ($urandom_range(1, 1 + idle_pct / 12)) @(posedge i_clk);
        end
    endtask

    // Holds off until every outstanding result beat has come back.
    // The first edge lets the checker log the beat accepted at this edge.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Clears, then fills the store to capacity with distinct keys in shuffled order,
    // and pokes at the full store: refused insert, duplicate insert, member check, delete, refill.
    task automatic fill_to_capacity();
        sks_pkg::t_key fill_keys [CAP];
        sks_pkg::t_key swap;
        int unsigned   i;
        int unsigned   j;
        int unsigned   hi_top;
        hi_top = 65536 / CAP - 1;
        issue(sks_pkg::MODE_CLEAR, sks_pkg::t_key'($urandom));
        // Distinct residues modulo CAP keep the keys unique while the upper part is random.
        for (i = 0; i < CAP; i++)
            fill_keys[i] = sks_pkg::t_key'(i + CAP * $urandom_range(0, hi_top));
        for (i = CAP - 1; i > 0; i--) begin
            j            = $urandom_range(0, i);
            swap         = fill_keys[i];
            fill_keys[i] = fill_keys[j];
            fill_keys[j] = swap;
        end
        for (i = 0; i < CAP; i++)
            issue(sks_pkg::MODE_INSERT, fill_keys[i]);
        j = $urandom_range(0, CAP - 1);
        issue(sks_pkg::MODE_INSERT, fill_keys[j] ^ 16'h8000);  // always absent: refused
        // duplicate on full store
        issue(sks_pkg::MODE_INSERT, fill_keys[$urandom_range(0, CAP - 1)]);
        issue(sks_pkg::MODE_MEMBER, fill_keys[j]);
        issue(sks_pkg::MODE_DELETE, fill_keys[j]);
        issue(sks_pkg::MODE_INSERT, fill_keys[j] ^ 16'h8000);  // takes the freed slot
        issue(sks_pkg::MODE_INSERT, fill_keys[j]);             // full again: refused
    endtask

    // Random traffic around a small key pool so that hits, duplicates and a full store
    // all come up; the rest are wide random keys, extremes and pool neighbors.
    task automatic random_traffic(input int n);
        sks_pkg::t_key  pool [128];
        int unsigned    pool_n;
        int unsigned    r;
        int             i;
        int unsigned    p;
        sks_pkg::t_mode mode;
        sks_pkg::t_key  key;
        pool_n = 1;
        for (i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                pool_n = $urandom_range(4, 100);
                for (p = 0; p < pool_n; p++)
                    pool[p] = sks_pkg::t_key'($urandom);
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                mode = sks_pkg::MODE_CLEAR;
            else if (r < 48)
                mode = sks_pkg::MODE_INSERT;
            else if (r < 72)
                mode = sks_pkg::MODE_DELETE;
            else
                mode = sks_pkg::MODE_MEMBER;
            r = $urandom_range(0, 99);
            if (r < 55)
                key = pool[$urandom_range(0, pool_n - 1)];
            else if (r < 75)
                key = sks_pkg::t_key'($urandom);
            else if (r < 85)
                key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
                key = pool[$urandom_range(0, pool_n - 1)] + ($urandom_range(0, 1) ? 16'h0001
                                                                                : 16'hFFFF);
            issue(mode, key);
        end
    endtask

    initial begin
        int phase;
        int phase_idle [4];
        phase_idle = '{0, 83, 0, 24};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-set corners, both key extremes, duplicates, misses,
        // deletes at the head, middle and tail, clear of a non-empty set.
        issue(sks_pkg::MODE_CLEAR,  16'h0000);
        issue(sks_pkg::MODE_MEMBER, 16'h0000);
        issue(sks_pkg::MODE_DELETE, 16'hFFFF);
        issue(sks_pkg::MODE_INSERT, 16'h0000);
        issue(sks_pkg::MODE_INSERT, 16'hFFFF);
        issue(sks_pkg::MODE_INSERT, 16'h0000);
        issue(sks_pkg::MODE_MEMBER, 16'h0000);
        issue(sks_pkg::MODE_MEMBER, 16'hFFFF);
        issue(sks_pkg::MODE_MEMBER, 16'h0001);
        issue(sks_pkg::MODE_INSERT, 16'h8000);
        issue(sks_pkg::MODE_INSERT, 16'h7FFF);
        issue(sks_pkg::MODE_INSERT, 16'h5555);
        issue(sks_pkg::MODE_INSERT, 16'hAAAA);
        issue(sks_pkg::MODE_DELETE, 16'h0001);
        issue(sks_pkg::MODE_DELETE, 16'h7FFF);
        issue(sks_pkg::MODE_DELETE, 16'h0000);
        issue(sks_pkg::MODE_DELETE, 16'hFFFF);
        issue(sks_pkg::MODE_MEMBER, 16'h7FFF);
        issue(sks_pkg::MODE_CLEAR,  16'hFFFF);
        issue(sks_pkg::MODE_MEMBER, 16'h8000);
        issue(sks_pkg::MODE_INSERT, 16'h1234);
        issue(sks_pkg::MODE_DELETE, 16'h1234);
        drain_results();

        // Phases differ in how often the sender goes quiet; each drains fully at the end.
        for (phase = 0; phase < 4; phase++) begin
            idle_pct = phase_idle[phase];
            fill_to_capacity();
            random_traffic(130);
            drain_results();
        end

        idle_pct = 0;
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sorted_key_set_engine.f */
+incdir+hw/rtl
hw/rtl/sks_pkg.sv
hw/rtl/sks_cell.sv
hw/rtl/sorted_key_set_engine.sv
tb/sorted_key_set_engine_checker.sv
tb/sorted_key_set_engine_tb.sv
